// ===== sv/sobel_edge_direction_contrast_macros.svh =====
// Assertion macros shared by the edge detector modules.
`ifndef SOBEL_EDGE_DIRECTION_CONTRAST_MACROS_SVH
`define SOBEL_EDGE_DIRECTION_CONTRAST_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SEDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SEDE_ASSERT_IMPLY(label, ante, cons, msg) \
  `SEDE_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/sede_pkg.sv =====
// Types and constants of the Sobel edge direction contrast block.
package sede_pkg;

  typedef logic [7:0]         pix_t;
  typedef logic [10:0]        coord_t;
  typedef logic signed [10:0] grad_t;
  typedef logic [11:0]        cfg_data_t;
  typedef logic [1:0]         cfg_idx_t;

  // 3x3 neighborhood, indexed [row][column], row 0 is the oldest line.
  typedef logic [2:0][2:0][7:0] win_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_IMAGE_WIDTH        = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT       = 2'd1;
  localparam cfg_idx_t CFG_CONTRAST_THRESHOLD = 2'd2;

  // Register values after reset.
  localparam logic [11:0] RST_IMAGE_WIDTH        = 12'd640;
  localparam logic [11:0] RST_IMAGE_HEIGHT       = 12'd480;
  localparam logic [7:0]  RST_CONTRAST_THRESHOLD = 8'd16;

  // Step along the gradient in one axis.
  typedef enum logic [1:0] {
    STEP_ZERO = 2'b00,
    STEP_POS  = 2'b01,
    STEP_NEG  = 2'b11
  } step_t;

  // Position information that travels with each pixel.
  typedef struct packed {
    logic   emit;
    coord_t row;
    coord_t col;
    logic   fend;
  } tag_t;

  // One result item.
  typedef struct packed {
    logic   edge_res;
    coord_t row;
    coord_t col;
    logic   fend;
  } res_t;

endpackage

// ===== sv/sede_if.sv =====
// Stream interfaces for the pixel input and the edge result output.
interface sede_pix_if;
  import sede_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sede_res_if;
  import sede_pkg::*;
  logic   valid;
  logic   ready;
  logic   edge_res;
  coord_t center_row;
  coord_t center_col;
  logic   frame_end;
  modport source (output valid, output edge_res, output center_row, output center_col,
                  output frame_end, input ready);
  modport sink (input valid, input edge_res, input center_row, input center_col,
                input frame_end, output ready);
endinterface

// ===== sv/sede_ram.sv =====
// Generic single write port RAM with one registered read port.
module sede_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds when no read is requested.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sede_decide.sv =====
// Gradient, step direction and contrast decision stages with the result register.
`include "sobel_edge_direction_contrast_macros.svh"

module sede_decide (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sede_pkg::tag_t in_tag,
  input  sede_pkg::win_t in_win,
  input  sede_pkg::pix_t thr,
  input  logic           out_ready,
  output logic           adv,
  output logic           res_valid,
  output sede_pkg::res_t res
);
  import sede_pkg::*;

  function automatic grad_t ext(input pix_t p);
    ext = grad_t'({3'b000, p});
  endfunction

  // Gradient stage registers.
  logic  s3_v_r;
  tag_t  s3_tag_r;
  win_t  s3_win_r;
  grad_t s3_fx_r, s3_fy_r;

  // Direction stage registers.
  logic  s4_v_r;
  tag_t  s4_tag_r;
  win_t  s4_win_r;
  step_t s4_sx_r, s4_sy_r;
  logic  s4_zero_r;

  // Result register.
  logic  res_valid_r;
  res_t  res_r;

  grad_t       fx_nxt, fy_nxt;
  logic [10:0] fx_neg, fy_neg;
  logic [9:0]  afx, afy;
  logic [19:0] sqx, sqy;
  logic [21:0] tx, ty;
  step_t       sx_nxt, sy_nxt;
  pix_t        sel_s, sel_e;
  logic [8:0]  dif, dif_neg;
  logic [7:0]  adif;
  res_t        res_nxt;

  // The pipeline moves unless a result waits and the last stage holds another one.
  assign adv = !res_valid_r || out_ready || !s4_v_r;

  // Sobel gradients of the current window.
  always_comb begin
    fy_nxt = ext(in_win[0][0]) + (ext(in_win[0][1]) <<< 1) + ext(in_win[0][2])
           - ext(in_win[2][0]) - (ext(in_win[2][1]) <<< 1) - ext(in_win[2][2]);
    fx_nxt = ext(in_win[0][2]) + (ext(in_win[1][2]) <<< 1) + ext(in_win[2][2])
           - ext(in_win[0][0]) - (ext(in_win[1][0]) <<< 1) - ext(in_win[2][0]);
  end

  // Step choice: sign of a component when three times its square reaches the other square.
  always_comb begin
    fx_neg = 11'd0 - s3_fx_r;
    fy_neg = 11'd0 - s3_fy_r;
    afx    = s3_fx_r[10] ? fx_neg[9:0] : s3_fx_r[9:0];
    afy    = s3_fy_r[10] ? fy_neg[9:0] : s3_fy_r[9:0];
    sqx    = 20'(afx) * 20'(afx);
    sqy    = 20'(afy) * 20'(afy);
    tx     = 22'({sqx, 1'b0}) + 22'(sqx);
    ty     = 22'({sqy, 1'b0}) + 22'(sqy);
    sx_nxt = STEP_ZERO;
    sy_nxt = STEP_ZERO;
    if (tx >= 22'(sqy) && s3_fx_r != '0) begin
      sx_nxt = s3_fx_r[10] ? STEP_NEG : STEP_POS;
    end
    if (ty >= 22'(sqx) && s3_fy_r != '0) begin
      sy_nxt = s3_fy_r[10] ? STEP_NEG : STEP_POS;
    end
  end

  // Neighbors ahead of and behind the center along the step, and their contrast.
  always_comb begin
    case ({s4_sx_r, s4_sy_r})
      {STEP_ZERO, STEP_POS}: begin sel_s = s4_win_r[2][1]; sel_e = s4_win_r[0][1]; end
      {STEP_ZERO, STEP_NEG}: begin sel_s = s4_win_r[0][1]; sel_e = s4_win_r[2][1]; end
      {STEP_POS, STEP_ZERO}: begin sel_s = s4_win_r[1][2]; sel_e = s4_win_r[1][0]; end
      {STEP_NEG, STEP_ZERO}: begin sel_s = s4_win_r[1][0]; sel_e = s4_win_r[1][2]; end
      {STEP_POS, STEP_POS}:  begin sel_s = s4_win_r[2][2]; sel_e = s4_win_r[0][0]; end
      {STEP_POS, STEP_NEG}:  begin sel_s = s4_win_r[0][2]; sel_e = s4_win_r[2][0]; end
      {STEP_NEG, STEP_POS}:  begin sel_s = s4_win_r[2][0]; sel_e = s4_win_r[0][2]; end
      {STEP_NEG, STEP_NEG}:  begin sel_s = s4_win_r[0][0]; sel_e = s4_win_r[2][2]; end
      default:               begin sel_s = s4_win_r[1][1]; sel_e = s4_win_r[1][1]; end
    endcase
    dif              = {1'b0, sel_e} - {1'b0, sel_s};
    dif_neg          = 9'd0 - dif;
    adif             = dif[8] ? dif_neg[7:0] : dif[7:0];
    res_nxt.edge_res = !s4_zero_r && (adif > thr);
    res_nxt.row      = s4_tag_r.row;
    res_nxt.col      = s4_tag_r.col;
    res_nxt.fend     = s4_tag_r.fend;
  end

  // Stage valid bits; only items that produce a result are carried.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s3_v_r <= in_valid && in_tag.emit;
        s4_v_r <= s3_v_r;
      end
      if (adv && s4_v_r) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tag_r  <= in_tag;
      s3_win_r  <= in_win;
      s3_fx_r   <= fx_nxt;
      s3_fy_r   <= fy_nxt;
      s4_tag_r  <= s3_tag_r;
      s4_win_r  <= s3_win_r;
      s4_sx_r   <= sx_nxt;
      s4_sy_r   <= sy_nxt;
      s4_zero_r <= (s3_fx_r == '0) && (s3_fy_r == '0);
    end
    if (adv && s4_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `SEDE_ASSERT(a_pending_kept,
               (s4_v_r && res_valid_r && !out_ready) |=> (s4_v_r && res_valid_r),
               "pending result lost during stall")
  `SEDE_ASSERT_IMPLY(a_zero_no_step, (s4_v_r && s4_zero_r),
                     (s4_sx_r == STEP_ZERO && s4_sy_r == STEP_ZERO),
                     "zero gradient produced a step")
  `SEDE_ASSERT_IMPLY(a_step_present, (s4_v_r && !s4_zero_r),
                     (s4_sx_r != STEP_ZERO || s4_sy_r != STEP_ZERO),
                     "nonzero gradient produced no step")

endmodule

// ===== sv/sobel_edge_direction_contrast.sv =====
// Streaming 3x3 Sobel edge detector with a directional contrast test.
//
// Grey pixels enter in raster order at one pixel per clock while the output is
// not stalled, and each interior pixel yields one result item that flags whether
// the contrast along its gradient direction exceeds contrast_threshold; border
// pixels yield nothing. The pixel that completes a window is carried through the
// first, window, gradient and direction stages into the result register. The
// rate is set by the two line stores, each a RAM with one write and one registered
// read per clock; all other work runs in a pipeline of short stages, and the input
// keeps taking pixels while a result waits as long as the stage before the result
// register is free. Line store contents are undefined until the first two rows of
// a frame have been written, so no clearing pass runs after reset. Width and height
// are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; a new size takes effect at once.
`include "sobel_edge_direction_contrast_macros.svh"

module sobel_edge_direction_contrast #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  sede_pix_if.sink            in_px,
  sede_res_if.source          out_res,
  input  logic                cfg_we,
  input  sede_pkg::cfg_idx_t  cfg_index,
  input  sede_pkg::cfg_data_t cfg_data
);
  import sede_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;
  localparam int CXW = (AW > 11) ? AW : 11;
  localparam int RXW = (RW > 11) ? RW : 11;

  // Configuration registers.
  logic [11:0] width_r, height_r;
  pix_t        thr_r;

  // Position of the next incoming pixel.
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Stage after the transfer: RAM read data arrives alongside these.
  logic          s1_v_r;
  tag_t          s1_tag_r;
  pix_t          s1_px_r;
  logic [AW-1:0] s1_col_r;

  // Window stage.
  logic s2_v_r;
  tag_t s2_tag_r;
  win_t win_r;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [WW-1:0]  col_p1;
  logic [HW-1:0]  row_p1;
  logic [CXW-1:0] col_m1;
  logic [RXW-1:0] row_m1;
  tag_t           tag_nxt;
  logic           in_acc;
  logic           adv;
  logic           ram_we;
  pix_t           rd_upper, rd_middle;
  logic           res_valid;
  res_t           res;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      thr_r    <= RST_CONTRAST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:        width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:       height_r <= cfg_data;
        CFG_CONTRAST_THRESHOLD: thr_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Frame size clamped to the supported range.
  always_comb begin
    w_eff = WW'(width_r);
    if (WW'(width_r) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = HW'(height_r);
    if (HW'(height_r) < HW'(3)) begin
      h_eff = HW'(3);
    end else if (HW'(height_r) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end
  end

  assign in_acc      = in_px.valid && in_px.ready;
  assign in_px.ready = adv;

  // Next position and the tag of the incoming pixel.
  always_comb begin
    col_p1       = WW'(col_r) + WW'(1);
    row_p1       = HW'(row_r) + HW'(1);
    col_m1       = CXW'(col_r) - CXW'(1);
    row_m1       = RXW'(row_r) - RXW'(1);
    tag_nxt.emit = (col_r >= AW'(2)) && (row_r >= RW'(2))
                && (WW'(col_r) < w_eff) && (HW'(row_r) < h_eff);
    tag_nxt.row  = row_m1[10:0];
    tag_nxt.col  = col_m1[10:0];
    tag_nxt.fend = (row_p1 == h_eff) && (col_p1 == w_eff);
    if (col_p1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_p1 >= h_eff) ? '0 : row_p1[RW-1:0];
    end else begin
      col_nxt = col_p1[AW-1:0];
      row_nxt = row_r;
    end
  end

  // Position counters and stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      win_r  <= '0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (adv) begin
        s1_v_r <= in_acc;
        s2_v_r <= s1_v_r;
      end
      // Shift the window one column and bring in the new column.
      if (adv && s1_v_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= rd_upper;
        win_r[1][2] <= rd_middle;
        win_r[2][2] <= s1_px_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r <= tag_nxt;
      s1_px_r  <= in_px.pixel;
      s1_col_r <= col_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  // Line stores: the middle row moves up and the new pixel becomes the middle row.
  assign ram_we = adv && s1_v_r;

  sede_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (rd_middle),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_upper)
  );

  sede_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_middle)
  );

  sede_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_tag    (s2_tag_r),
    .in_win    (win_r),
    .thr       (thr_r),
    .out_ready (out_res.ready),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_res.valid      = res_valid;
  assign out_res.edge_res   = res.edge_res;
  assign out_res.center_row = res.row;
  assign out_res.center_col = res.col;
  assign out_res.frame_end  = res.fend;

  `SEDE_ASSERT_IMPLY(a_ram_no_collide, (ram_we && in_acc), (s1_col_r != col_r),
                     "line store read and write hit one address")
  `SEDE_ASSERT(a_row_wrap, (in_acc && col_p1 >= w_eff) |=> (col_r == '0),
               "column did not wrap at row end")
  `SEDE_ASSERT(a_s1_held, (s1_v_r && !adv) |=> s1_v_r,
               "stalled pixel left the first stage")

endmodule
